>>> rtl/qoi_image_decoder_macros.svh
// ----------------------------------------------------------------------------
// QOI image decoder assertion macros
// Shared property shapes for the checker of the QOI decoder.
// ----------------------------------------------------------------------------
`ifndef QOI_IMAGE_DECODER_MACROS_SVH
`define QOI_IMAGE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QOI_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qoi decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QOI_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qoi decoder assertion failed");

`endif

>>> rtl/qoi_pkg.sv
// ----------------------------------------------------------------------------
// QOI decoder package
// Shared widths, chunk codes, status codes, result type and the table hash.
// ----------------------------------------------------------------------------
`default_nettype none

package qoi_pkg;

    localparam int PIX_W    = 32;
    localparam int HASH_W   = 6;
    localparam int TBL_DEPTH = 1 << HASH_W;
    localparam int CNT_W    = 32;
    localparam int RUN_W    = 6;
    localparam int ADDR_W   = 3;

    // Register index of the expected pixel count.
    localparam logic REG_PIXEL_COUNT = 1'b0;

    // Chunk opcodes and two-bit tags.
    localparam logic [7:0] OP_RGB   = 8'hFE;
    localparam logic [7:0] OP_RGBA  = 8'hFF;
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    // Multi-byte chunk still being assembled.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_LUMA = 2'd1;
    localparam logic [1:0] KIND_RGB  = 2'd2;
    localparam logic [1:0] KIND_RGBA = 2'd3;

    // End-of-image status.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd2;

    // Pixel after reset: opaque black, packed r,g,b,a from the top byte down.
    localparam logic [PIX_W-1:0] PIX_START = 32'h0000_00FF;

    typedef struct packed {
        logic [PIX_W-1:0] data;        // alpha, blue, green, red from the top
        logic             pixel_valid;
        logic             last;
        logic [1:0]       status;
    } qoi_result_t;

    // Table slot: (3r + 5g + 7b + 11a) mod 64, evaluated in six bits.
    function automatic logic [HASH_W-1:0] hash_f(input logic [PIX_W-1:0] px);
        logic [HASH_W-1:0] r6;
        logic [HASH_W-1:0] g6;
        logic [HASH_W-1:0] b6;
        logic [HASH_W-1:0] a6;
        r6 = px[24 +: HASH_W];
        g6 = px[16 +: HASH_W];
        b6 = px[8 +: HASH_W];
        a6 = px[0 +: HASH_W];
        return r6 * 6'd3 + g6 * 6'd5 + b6 * 6'd7 + a6 * 6'd11;
    endfunction

endpackage

`default_nettype wire

>>> rtl/qoi_cfg.sv
// ----------------------------------------------------------------------------
// QOI decoder configuration registers
// APB-style slave holding the expected pixel count.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_cfg (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [qoi_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output logic      [qoi_pkg::CNT_W-1:0]    pixel_count
);
    import qoi_pkg::*;

    logic [CNT_W-1:0] pixel_count_reg;
    logic [CNT_W-1:0] pixel_count_next;
    logic             wr_en;
    logic             sel_count;

    // Word index lives in the bit above the byte offset.
    assign sel_count = (paddr[ADDR_W-1] == REG_PIXEL_COUNT);
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb begin
        pixel_count_next = pixel_count_reg;
        if (wr_en && sel_count) begin
            pixel_count_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= '0;
        end else begin
            pixel_count_reg <= pixel_count_next;
        end
    end

    assign prdata      = sel_count ? pixel_count_reg : 32'd0;
    assign pixel_count = pixel_count_reg;

endmodule

`default_nettype wire

>>> rtl/qoi_obuf.sv
// ----------------------------------------------------------------------------
// QOI decoder output register
// One-entry result register that decouples the decoder from the result sink.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_obuf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire qoi_pkg::qoi_result_t in_result,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,
    output logic                      m_tlast,
    output logic [2:0]                m_tuser
);
    import qoi_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    qoi_result_t result_reg;
    qoi_result_t result_next;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next  = valid_reg;
        result_next = result_reg;
        if (in_ready) begin
            valid_next  = in_valid;
            result_next = in_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg.data;
    assign m_tlast  = result_reg.last;
    assign m_tuser  = {result_reg.status, result_reg.pixel_valid};

endmodule

`default_nettype wire

>>> rtl/qoi_dec.sv
// ----------------------------------------------------------------------------
// QOI chunk decoder
// Byte-level chunk sequencer around the recent-pixel table memory.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_dec (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,
    input  wire logic                       s_tlast,
    input  wire logic [qoi_pkg::CNT_W-1:0]  pixel_count,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output qoi_pkg::qoi_result_t            res_data
);
    import qoi_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]           state_reg,   state_next;
    logic [PIX_W-1:0]     prev_reg,    prev_next;
    logic [1:0]           kind_reg,    kind_next;
    logic [2:0]           need_reg,    need_next;
    logic [PIX_W-1:0]     part_reg,    part_next;
    logic [CNT_W-1:0]     emitted_reg, emitted_next;
    logic [TBL_DEPTH-1:0] tvalid_reg,  tvalid_next;
    logic [PIX_W-1:0]     px_reg,      px_next;
    logic [RUN_W-1:0]     cnt_reg,     cnt_next;
    logic                 fin_reg,     fin_next;
    logic                 pixv_reg,    pixv_next;
    logic [1:0]           stat_reg,    stat_next;
    logic [HASH_W-1:0]    idx_reg,     idx_next;

    // Recent-pixel table: one write port, one registered read port.
    logic [PIX_W-1:0]  tbl_mem [TBL_DEPTH];
    logic [PIX_W-1:0]  tbl_rdata_reg;
    logic              tbl_we;
    logic [HASH_W-1:0] tbl_waddr;

    logic             in_fire;
    logic [7:0]       pr, pg, pb, pa;
    logic [7:0]       dg, drdg, dbdg;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] emitted_sat;
    logic [PIX_W-1:0] out_px;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign pr = prev_reg[31:24];
    assign pg = prev_reg[23:16];
    assign pb = prev_reg[15:8];
    assign pa = prev_reg[7:0];

    // Luma deltas: green delta from the first byte, red/blue relative to it.
    assign dg   = {2'b00, part_reg[5:0]} - 8'd32;
    assign drdg = {4'b0000, s_tdata[7:4]} - 8'd8;
    assign dbdg = {4'b0000, s_tdata[3:0]} - 8'd8;

    // Pixel counter saturates at all ones.
    assign sum         = {1'b0, emitted_reg} + {{(CNT_W + 1 - RUN_W){1'b0}}, cnt_reg};
    assign emitted_sat = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

    assign tbl_we    = (state_reg == ST_WRITE);
    assign tbl_waddr = hash_f(px_reg);

    always_comb begin
        state_next   = state_reg;
        prev_next    = prev_reg;
        kind_next    = kind_reg;
        need_next    = need_reg;
        part_next    = part_reg;
        emitted_next = emitted_reg;
        tvalid_next  = tvalid_reg;
        px_next      = px_reg;
        cnt_next     = cnt_reg;
        fin_next     = fin_reg;
        pixv_next    = pixv_reg;
        stat_next    = stat_reg;
        idx_next     = idx_reg;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    fin_next  = s_tlast;
                    pixv_next = 1'b1;
                    cnt_next  = RUN_W'(1);
                    if (need_reg != 3'd0) begin
                        part_next = {part_reg[23:0], s_tdata};
                        need_next = need_reg - 3'd1;
                        if (need_reg == 3'd1) begin
                            case (kind_reg)
                                KIND_LUMA: px_next = {pr + dg + drdg, pg + dg,
                                                      pb + dg + dbdg, pa};
                                KIND_RGB:  px_next = {part_reg[15:0], s_tdata, pa};
                                default:   px_next = {part_reg[23:0], s_tdata};
                            endcase
                            kind_next  = KIND_NONE;
                            part_next  = '0;
                            state_next = ST_WRITE;
                        end
                    end else if (s_tdata == OP_RGB) begin
                        kind_next = KIND_RGB;
                        need_next = 3'd3;
                        part_next = '0;
                    end else if (s_tdata == OP_RGBA) begin
                        kind_next = KIND_RGBA;
                        need_next = 3'd4;
                        part_next = '0;
                    end else begin
                        case (s_tdata[7:6])
                            TAG_INDEX: begin
                                idx_next   = s_tdata[5:0];
                                state_next = ST_READ;
                            end
                            TAG_DIFF: begin
                                px_next = {pr + {6'd0, s_tdata[5:4]} - 8'd2,
                                           pg + {6'd0, s_tdata[3:2]} - 8'd2,
                                           pb + {6'd0, s_tdata[1:0]} - 8'd2, pa};
                                state_next = ST_WRITE;
                            end
                            TAG_LUMA: begin
                                kind_next = KIND_LUMA;
                                need_next = 3'd1;
                                part_next = {24'd0, s_tdata};
                            end
                            default: begin
                                px_next    = prev_reg;
                                cnt_next   = s_tdata[5:0] + RUN_W'(1);
                                state_next = ST_WRITE;
                            end
                        endcase
                    end
                    // A final byte that completes no pixel still owes one
                    // status-only transfer.
                    if (s_tlast && (state_next == ST_IDLE)) begin
                        pixv_next  = 1'b0;
                        px_next    = '0;
                        cnt_next   = RUN_W'(1);
                        if (need_next != 3'd0) begin
                            stat_next = STATUS_TRUNCATED;
                        end else if (emitted_reg != pixel_count) begin
                            stat_next = STATUS_MISMATCH;
                        end else begin
                            stat_next = STATUS_OK;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_READ: begin
                px_next    = tvalid_reg[idx_reg] ? tbl_rdata_reg : '0;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                prev_next              = px_reg;
                tvalid_next[tbl_waddr] = 1'b1;
                emitted_next           = emitted_sat;
                stat_next = (emitted_sat != pixel_count) ? STATUS_MISMATCH : STATUS_OK;
                state_next             = ST_EMIT;
            end
            default: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    cnt_next = cnt_reg - RUN_W'(1);
                    if (cnt_reg == RUN_W'(1)) begin
                        state_next = ST_IDLE;
                        if (fin_reg) begin
                            prev_next    = PIX_START;
                            kind_next    = KIND_NONE;
                            need_next    = 3'd0;
                            part_next    = '0;
                            emitted_next = '0;
                            tvalid_next  = '0;
                        end
                    end
                end
            end
        endcase
    end

    assign out_px = pixv_reg ? px_reg : '0;

    always_comb begin
        res_data.data        = {out_px[7:0], out_px[15:8], out_px[23:16], out_px[31:24]};
        res_data.pixel_valid = pixv_reg;
        res_data.last        = (cnt_reg == RUN_W'(1));
        res_data.status      = (fin_reg && (cnt_reg == RUN_W'(1))) ? stat_reg : STATUS_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prev_reg    <= PIX_START;
            kind_reg    <= KIND_NONE;
            need_reg    <= 3'd0;
            part_reg    <= '0;
            emitted_reg <= '0;
            tvalid_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            prev_reg    <= prev_next;
            kind_reg    <= kind_next;
            need_reg    <= need_next;
            part_reg    <= part_next;
            emitted_reg <= emitted_next;
            tvalid_reg  <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg   <= px_next;
        cnt_reg  <= cnt_next;
        fin_reg  <= fin_next;
        pixv_reg <= pixv_next;
        stat_reg <= stat_next;
        idx_reg  <= idx_next;
    end

    // The address is the index chunk's low six bits; the registered data is used
    // in the next cycle, in ST_READ.
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= px_reg;
        end
        tbl_rdata_reg <= tbl_mem[s_tdata[5:0]];
    end

endmodule

`default_nettype wire

>>> rtl/qoi_image_decoder.sv
// ----------------------------------------------------------------------------
// QOI image decoder
// Decodes a QOI chunk stream, one byte per transfer, into RGBA pixels.
// ----------------------------------------------------------------------------
// Flow: a byte that completes a pixel passes the table write-back step before
//   its result reaches the output register (an index chunk first waits on the
//   table read). A run issues one result per cycle while the output register
//   accepts. A new byte is taken only once the previous results are issued.
// Reset: synchronous, active low; the table clears at once through valid bits.
`default_nettype none

module qoi_image_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Compressed input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte

    // Decoded pixel stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output logic             m_tlast,   // last
    output logic [2:0]       m_tuser,   // [0] pixel_valid, [2:1] status

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import qoi_pkg::*;

    // Expected image size from the register block.
    logic [CNT_W-1:0] pixel_count;

    // Decoder to output register.
    logic        res_valid;
    logic        res_ready;
    qoi_result_t res_data;

    // The register block must be written only while the decoder is idle, a duty of the user
    // that the block leaves unchecked, so the count it hands over is stable for the whole image.
    qoi_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_count (pixel_count)
    );

    // The decoder takes one byte at a time. Between bytes it reads the
    // recent-pixel table for an index chunk, writes the new pixel back at its hash
    // slot and then issues one result per cycle while the output register accepts.
    // Because a byte is accepted only once the write-back of the previous pixel is
    // done, a later index read never overlaps an earlier write to the same slot.
    qoi_dec u_dec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .pixel_count (pixel_count),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    // The output register holds a finished result while the decoder goes on
    // accepting bytes that complete no pixel.
    qoi_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_result (res_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/qoi_dec_checker.sv
// ----------------------------------------------------------------------------
// QOI decoder port checker
// Watches the top-level ports for result and register behavior over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "qoi_image_decoder_macros.svh"

module qoi_dec_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [2:0]  m_tuser,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);
    import qoi_pkg::*;

    logic cfg_wr;
    logic in_seen;
    logic in_chunk;

    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[ADDR_W-1] == REG_PIXEL_COUNT);
    assign in_seen  = s_tvalid && s_tready;
    assign in_chunk = (s_tdata != OP_RGB) && (s_tdata != OP_RGBA);

    // A status code rides only on the closing transfer of a byte.
    `QOI_ASSERT_IMP(a_status_on_last, aclk, aresetn, m_tvalid && (m_tuser[2:1] != STATUS_OK), m_tlast)

    // A status-only result carries a zero pixel and closes its byte.
    `QOI_ASSERT_IMP(a_status_only_shape, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 32'd0 && m_tlast)

    // The final byte of an image always owes a result, so the input stops.
    `QOI_ASSERT_NXT(a_final_byte_stalls, aclk, aresetn, in_seen && s_tlast && (in_chunk || !in_chunk), !s_tready)

    // The count register reads back what was written.
    `QOI_ASSERT_NXT(a_count_readback, aclk, aresetn, cfg_wr, prdata == $past(pwdata))

    // A stalled result holds.
    `QOI_ASSERT_NXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind qoi_image_decoder qoi_dec_checker u_qoi_dec_checker (.*);

`default_nettype wire
